FILE: rtl/pivr_pkg.sv
`timescale 1ns / 1ps

package pivr_pkg;

  // Field widths
  localparam int VoltW   = 32;                 // Q16.16 voltages and outputs
  localparam int ErrW    = VoltW + 1;          // Q17.16 error
  localparam int GainW   = 31;                 // Q15.16 unsigned gains
  localparam int StepW   = 32;                 // Q0.32 time step
  localparam int IntW    = 48;                 // Q16.32 integral
  localparam int LimW    = 47;                 // integral bound
  localparam int CfgDataW = 47;
  localparam int CfgIdxW  = 3;
  localparam int HalfIntW = IntW / 2;

  // Shared multiplier: signed ErrW x unsigned 32 bits
  localparam int MulBW   = 32;
  localparam int ProdW   = ErrW + MulBW;       // kept product width
  localparam int PartW   = HalfIntW + GainW;   // integral partial product width

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_VREF = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KP   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KI   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LIM  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OMIN = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_OMAX = 3'd6;

  // Multiplier operand selection
  localparam logic [1:0] MUL_STEP   = 2'd0;  // error * time step
  localparam logic [1:0] MUL_KP     = 2'd1;  // error * kp
  localparam logic [1:0] MUL_INT_HI = 2'd2;  // integral upper half * ki
  localparam logic [1:0] MUL_INT_LO = 2'd3;  // integral lower half * ki

  // Controller to datapath commands
  typedef struct packed {
    logic       load_err;
    logic [1:0] mul_sel;
    logic       upd_int;
    logic       cap_p;
    logic       cap_hi;
    logic       sum_i;
    logic       load_out;
  } pivr_cmd_t;

endpackage

FILE: rtl/pi_voltage_regulator.sv
`timescale 1ns / 1ps
// One item is in flight at a time; the single shared multiplier is used four
// times per item, followed by a recombine step and a sum/clamp step.
// A held output result does not block accepting the next item, only its load-out.
// Reset (rst_n, synchronous, active low) clears config registers and the integral.
module pi_voltage_regulator
  import pivr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CfgDataW-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VoltW-1:0] in_measured_voltage,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VoltW-1:0] out_power_reference
);

  pivr_cmd_t cmd;

  pivr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pivr_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_measured_voltage (in_measured_voltage),
    .cmd                 (cmd),
    .out_power_reference (out_power_reference)
  );

endmodule

FILE: rtl/pivr_ctrl.sv
`timescale 1ns / 1ps

module pivr_ctrl
  import pivr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output pivr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_M1    = 3'd1;
  localparam logic [2:0] S_M2    = 3'd2;
  localparam logic [2:0] S_M3    = 3'd3;
  localparam logic [2:0] S_M4    = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_CLAMP = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Sequencer: one item walks through the shared multiplier four times
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_STEP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_err = 1'b1;
          state_nxt    = S_M1;
        end
      end
      S_M1: begin
        cmd.mul_sel = MUL_STEP;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.mul_sel = MUL_KP;
        cmd.upd_int = 1'b1;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.mul_sel = MUL_INT_HI;
        cmd.cap_p   = 1'b1;
        state_nxt   = S_M4;
      end
      S_M4: begin
        cmd.mul_sel = MUL_INT_LO;
        cmd.cap_hi  = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.sum_i = 1'b1;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        // wait here until the output register can take the result
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = (out_valid_r && out_stall) || cmd.load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/pivr_dp.sv
`timescale 1ns / 1ps

module pivr_dp
  import pivr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CfgIdxW-1:0]         cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data,
  input  logic signed [VoltW-1:0]    in_measured_voltage,
  input  pivr_cmd_t                  cmd,
  output logic signed [VoltW-1:0]    out_power_reference
);

  // Configuration registers
  logic signed [VoltW-1:0] vref_r, omin_r, omax_r;
  logic [StepW-1:0]        step_r;
  logic [GainW-1:0]        kp_r, ki_r;
  logic [LimW-1:0]         lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r <= '0;
      step_r <= '0;
      kp_r   <= '0;
      ki_r   <= '0;
      lim_r  <= '0;
      omin_r <= '0;
      omax_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VREF: vref_r <= cfg_data[VoltW-1:0];
        CFG_STEP: step_r <= cfg_data[StepW-1:0];
        CFG_KP:   kp_r   <= cfg_data[GainW-1:0];
        CFG_KI:   ki_r   <= cfg_data[GainW-1:0];
        CFG_LIM:  lim_r  <= cfg_data[LimW-1:0];
        CFG_OMIN: omin_r <= cfg_data[VoltW-1:0];
        CFG_OMAX: omax_r <= cfg_data[VoltW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [ErrW-1:0]  err_r;
  logic signed [IntW-1:0]  integ_r;
  logic signed [ProdW-1:0] prod_r;
  logic signed [IntW-1:0]  p_r;
  logic signed [PartW-1:0] ihi_r;
  logic signed [IntW-1:0]  iterm_r;
  logic signed [VoltW-1:0] out_r;

  // Shared multiplier operand selection
  logic signed [ErrW-1:0]    mul_a;
  logic [MulBW-1:0]          mul_b;
  logic signed [ErrW+MulBW:0] mul_full;

  always_comb begin
    case (cmd.mul_sel)
      MUL_STEP: begin
        mul_a = err_r;
        mul_b = step_r;
      end
      MUL_KP: begin
        mul_a = err_r;
        mul_b = {1'b0, kp_r};
      end
      MUL_INT_HI: begin
        mul_a = {{(ErrW-HalfIntW){integ_r[IntW-1]}}, integ_r[IntW-1:HalfIntW]};
        mul_b = {1'b0, ki_r};
      end
      MUL_INT_LO: begin
        mul_a = {{(ErrW-HalfIntW){1'b0}}, integ_r[HalfIntW-1:0]};
        mul_b = {1'b0, ki_r};
      end
      default: begin
        mul_a = err_r;
        mul_b = step_r;
      end
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // Integral update: floor the step increment, add, clamp to +/- limit
  logic signed [IntW+1:0] inc_ext, sum_ext, lim_pos, lim_neg, sum_cl;

  always_comb begin
    inc_ext = {prod_r[ProdW-1], prod_r[ProdW-1:16]};
    sum_ext = {{2{integ_r[IntW-1]}}, integ_r} + inc_ext;
    lim_pos = {3'b000, lim_r};
    lim_neg = -lim_pos;
    sum_cl  = sum_ext;
    if (sum_cl > lim_pos) sum_cl = lim_pos;
    if (sum_cl < lim_neg) sum_cl = lim_neg;
  end

  // Integral term: recombine the two partial products, floor by 2^32
  logic signed [PartW+HalfIntW:0] iwide;

  assign iwide = ({ihi_r[PartW-1], ihi_r, {HalfIntW{1'b0}}})
               + {{(HalfIntW+1){1'b0}}, prod_r[PartW-1:0]};

  // Output sum and clamp: lower bound first, upper bound wins
  logic signed [IntW:0] y_sum, y_cl, omin_ext, omax_ext;

  always_comb begin
    y_sum    = {p_r[IntW-1], p_r} + {iterm_r[IntW-1], iterm_r};
    omin_ext = {{(IntW+1-VoltW){omin_r[VoltW-1]}}, omin_r};
    omax_ext = {{(IntW+1-VoltW){omax_r[VoltW-1]}}, omax_r};
    y_cl     = y_sum;
    if (y_cl < omin_ext) y_cl = omin_ext;
    if (y_cl > omax_ext) y_cl = omax_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (cmd.upd_int) begin
      integ_r <= sum_cl[IntW-1:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_full[ProdW-1:0];
    if (cmd.load_err) err_r   <= {vref_r[VoltW-1], vref_r}
                               - {in_measured_voltage[VoltW-1], in_measured_voltage};
    if (cmd.cap_p)    p_r     <= prod_r[ProdW-2:16];
    if (cmd.cap_hi)   ihi_r   <= prod_r[PartW-1:0];
    if (cmd.sum_i)    iterm_r <= iwide[PartW+HalfIntW:32];
    if (cmd.load_out) out_r   <= y_cl[VoltW-1:0];
  end

  assign out_power_reference = out_r;

endmodule

FILE: rtl/pivr_checker.sv
`timescale 1ns / 1ps

module pivr_checker
  import pivr_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VoltW-1:0] out_power_reference
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_power_reference))
    else $error("stalled result changed");

  // One item at a time: busy right after an accept
  a_busy_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in flight");

  // Still busy in the sum state that follows the multiply sequence
  a_busy_late: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##5 in_stall)
    else $error("item finished too early");

  // A new result only comes out of a busy period
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an item in flight");

endmodule

bind pi_voltage_regulator pivr_checker u_pivr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_power_reference (out_power_reference)
);
